FILE: rtl/core/esf_pkg.sv
`timescale 1ns / 1ps

package esf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COORD_W   = 10;
  localparam int SIZE_W    = 11;
  localparam int PIX_W     = 8;
  localparam int CFG_IDX_W = 2;

  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int YW        = $clog2(MAX_HEIGHT);
  localparam int MAP_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);

  localparam logic [PIX_W-1:0] EDGE_VALUE = 8'd255;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CHECK  = 7'b0000010,
    ST_SCAN_L = 7'b0000100,
    ST_SCAN_R = 7'b0001000,
    ST_SCAN_U = 7'b0010000,
    ST_SCAN_D = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic load;
    logic query;
    logic check;
    logic init;
    dir_t init_dir;
    logic scan;
    dir_t scan_dir;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic done;
  } sts_t;

endpackage

FILE: rtl/core/esf_ram.sv
`timescale 1ns / 1ps

module esf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/esf_ctrl.sv
`timescale 1ns / 1ps

module esf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          func,
  input  esf_pkg::sts_t sts,
  output esf_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);

  esf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= esf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.init_dir = esf_pkg::DIR_LEFT;
    cmd.scan_dir = esf_pkg::DIR_LEFT;
    unique case (state_r)
      esf_pkg::ST_IDLE: begin
        if (start) begin
          if (func == esf_pkg::FUNC_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.query = 1'b1;
            state_nxt = esf_pkg::ST_CHECK;
          end
        end
      end
      esf_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        if (sts.bad) begin
          state_nxt = esf_pkg::ST_EMIT;
        end else begin
          cmd.init     = 1'b1;
          cmd.init_dir = esf_pkg::DIR_LEFT;
          state_nxt    = esf_pkg::ST_SCAN_L;
        end
      end
      esf_pkg::ST_SCAN_L: begin
        cmd.scan     = 1'b1;
        cmd.scan_dir = esf_pkg::DIR_LEFT;
        if (sts.done) begin
          cmd.init     = 1'b1;
          cmd.init_dir = esf_pkg::DIR_RIGHT;
          state_nxt    = esf_pkg::ST_SCAN_R;
        end
      end
      esf_pkg::ST_SCAN_R: begin
        cmd.scan     = 1'b1;
        cmd.scan_dir = esf_pkg::DIR_RIGHT;
        if (sts.done) begin
          cmd.init     = 1'b1;
          cmd.init_dir = esf_pkg::DIR_UP;
          state_nxt    = esf_pkg::ST_SCAN_U;
        end
      end
      esf_pkg::ST_SCAN_U: begin
        cmd.scan     = 1'b1;
        cmd.scan_dir = esf_pkg::DIR_UP;
        if (sts.done) begin
          cmd.init     = 1'b1;
          cmd.init_dir = esf_pkg::DIR_DOWN;
          state_nxt    = esf_pkg::ST_SCAN_D;
        end
      end
      esf_pkg::ST_SCAN_D: begin
        cmd.scan     = 1'b1;
        cmd.scan_dir = esf_pkg::DIR_DOWN;
        if (sts.done) begin
          state_nxt = esf_pkg::ST_EMIT;
        end
      end
      esf_pkg::ST_EMIT: begin
        state_nxt = esf_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = esf_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != esf_pkg::ST_IDLE);
  assign out_valid = (state_r == esf_pkg::ST_EMIT);

endmodule

FILE: rtl/core/esf_dpath.sv
`timescale 1ns / 1ps

module esf_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  esf_pkg::cmd_t                  cmd,
  output esf_pkg::sts_t                  sts,
  input  logic [esf_pkg::COORD_W-1:0]    coord_x,
  input  logic [esf_pkg::COORD_W-1:0]    coord_y,
  input  logic [esf_pkg::PIX_W-1:0]      pixel_value,
  input  logic                           cfg_wr,
  input  logic [esf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esf_pkg::SIZE_W-1:0]     cfg_data,
  output logic [esf_pkg::SIZE_W-1:0]     left_edge,
  output logic [esf_pkg::SIZE_W-1:0]     top_edge,
  output logic [esf_pkg::SIZE_W-1:0]     right_edge,
  output logic [esf_pkg::SIZE_W-1:0]     bottom_edge,
  output logic                           bad_query
);

  localparam int SW = esf_pkg::SIZE_W;
  localparam int AW = esf_pkg::ADDR_W;
  localparam logic [SW-1:0] MAXW = SW'(esf_pkg::MAX_WIDTH);
  localparam logic [SW-1:0] MAXH = SW'(esf_pkg::MAX_HEIGHT);

  logic [SW-1:0] width_r, height_r;
  logic [SW-1:0] w_r, h_r;
  logic [esf_pkg::COORD_W-1:0] qx_r, qy_r;
  logic [SW-1:0] cur_r, pend_r;
  logic          pend_vld_r;
  logic [SW-1:0] left_r, top_r, right_r, bottom_r;
  logic          bad_r;

  logic          wr_en, wr_in_map, rd_en, rd_bit;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [esf_pkg::XW-1:0] rd_x;
  logic [esf_pkg::YW-1:0] rd_y;
  logic          hit, in_range, backward;
  logic [SW-1:0] lim, cur_start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= MAXW;
      height_r <= MAXH;
    end else if (cfg_wr) begin
      if (cfg_index == esf_pkg::REG_WIDTH) begin
        width_r <= cfg_data;
      end
      if (cfg_index == esf_pkg::REG_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  // Load path: writes land directly from the input ports in the accept cycle.
  assign wr_in_map = ({1'b0, coord_x} < MAXW) && ({1'b0, coord_y} < MAXH);
  assign wr_en     = cmd.load && wr_in_map;
  assign wr_addr   = AW'(coord_y[esf_pkg::YW-1:0]) * AW'(esf_pkg::MAX_WIDTH)
                   + AW'(coord_x[esf_pkg::XW-1:0]);

  assign backward = (cmd.scan_dir == esf_pkg::DIR_LEFT) ||
                    (cmd.scan_dir == esf_pkg::DIR_UP);
  assign lim      = (cmd.scan_dir == esf_pkg::DIR_RIGHT) ? w_r : h_r;
  // A backward cursor that has stepped past zero shows up as a set top bit.
  assign in_range = backward ? !cur_r[SW-1] : (cur_r < lim);
  assign hit      = pend_vld_r && rd_bit;

  assign sts.done = hit || !in_range;
  assign sts.bad  = ({1'b0, qx_r} >= w_r) || ({1'b0, qy_r} >= h_r);

  always_comb begin
    if ((cmd.scan_dir == esf_pkg::DIR_LEFT) || (cmd.scan_dir == esf_pkg::DIR_RIGHT)) begin
      rd_x = cur_r[esf_pkg::XW-1:0];
      rd_y = qy_r[esf_pkg::YW-1:0];
    end else begin
      rd_x = qx_r[esf_pkg::XW-1:0];
      rd_y = cur_r[esf_pkg::YW-1:0];
    end
  end

  assign rd_en   = cmd.scan && in_range && !hit;
  assign rd_addr = AW'(rd_y) * AW'(esf_pkg::MAX_WIDTH) + AW'(rd_x);

  esf_ram #(
    .WIDTH (1),
    .DEPTH (esf_pkg::MAP_DEPTH)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (pixel_value == esf_pkg::EDGE_VALUE),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bit)
  );

  always_comb begin
    unique case (cmd.init_dir)
      esf_pkg::DIR_LEFT:  cur_start = {1'b0, qx_r} - SW'(1);
      esf_pkg::DIR_RIGHT: cur_start = {1'b0, qx_r} + SW'(1);
      esf_pkg::DIR_UP:    cur_start = {1'b0, qy_r} - SW'(1);
      esf_pkg::DIR_DOWN:  cur_start = {1'b0, qy_r} + SW'(1);
      default:            cur_start = {1'b0, qx_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else if (cmd.init) begin
      pend_vld_r <= 1'b0;
    end else if (cmd.scan) begin
      pend_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query) begin
      qx_r  <= coord_x;
      qy_r  <= coord_y;
      w_r   <= (width_r > MAXW) ? MAXW : width_r;
      h_r   <= (height_r > MAXH) ? MAXH : height_r;
      bad_r <= 1'b0;
    end
    if (cmd.check && sts.bad) begin
      left_r   <= '0;
      top_r    <= '0;
      right_r  <= '0;
      bottom_r <= '0;
      bad_r    <= 1'b1;
    end
    if (cmd.scan && hit) begin
      unique case (cmd.scan_dir)
        esf_pkg::DIR_LEFT:  left_r   <= pend_r;
        esf_pkg::DIR_RIGHT: right_r  <= pend_r;
        esf_pkg::DIR_UP:    top_r    <= pend_r;
        esf_pkg::DIR_DOWN:  bottom_r <= pend_r;
        default:            left_r   <= pend_r;
      endcase
    end
    if (cmd.init) begin
      cur_r <= cur_start;
      unique case (cmd.init_dir)
        esf_pkg::DIR_LEFT:  left_r   <= '1;
        esf_pkg::DIR_RIGHT: right_r  <= w_r;
        esf_pkg::DIR_UP:    top_r    <= '1;
        esf_pkg::DIR_DOWN:  bottom_r <= h_r;
        default:            left_r   <= '1;
      endcase
    end else if (rd_en) begin
      pend_r <= cur_r;
      cur_r  <= backward ? (cur_r - SW'(1)) : (cur_r + SW'(1));
    end
  end

  assign left_edge   = left_r;
  assign top_edge    = top_r;
  assign right_edge  = right_r;
  assign bottom_edge = bottom_r;
  assign bad_query   = bad_r;

endmodule

FILE: rtl/core/edge_span_finder.sv
`timescale 1ns / 1ps

// Edge span finder. Holds a one-bit edge map of up to 1024 x 1024 pixels.
// Command channel: start with in_func, in_coord_x, in_coord_y, in_pixel_value
// is taken when busy is low. A load (in_func = 0) stores whether the pixel is
// 255 and completes in the accept cycle; busy stays low and no result follows.
// A query (in_func = 1) raises busy and scans left, right, up and down from
// the point, one map read per cycle from the map RAM, which has a separate
// write port. Each scan direction ends early at its first edge, and a
// point outside the configured size skips all four scans. One query is in
// progress at a time, and the next transaction can be taken in the cycle
// after the result.
// The answer appears on the out_ ports for one cycle with out_valid high; the
// receiver cannot stall it. The configuration channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data) sets image width (index 0) and height (index 1); it is
// always ready and should be used only while the block is idle.
// Reset sets both sizes to 1024 and returns to idle. The map is not cleared:
// queries must only cover pixels that have been loaded.
module edge_span_finder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_func,
  input  logic [esf_pkg::COORD_W-1:0]          in_coord_x,
  input  logic [esf_pkg::COORD_W-1:0]          in_coord_y,
  input  logic [esf_pkg::PIX_W-1:0]            in_pixel_value,
  output logic                                 out_valid,
  output logic signed [esf_pkg::SIZE_W-1:0]    out_left_edge,
  output logic signed [esf_pkg::SIZE_W-1:0]    out_top_edge,
  output logic [esf_pkg::SIZE_W-1:0]           out_right_edge,
  output logic [esf_pkg::SIZE_W-1:0]           out_bottom_edge,
  output logic                                 out_bad_query,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [esf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [esf_pkg::SIZE_W-1:0]           cfg_data
);

  esf_pkg::cmd_t cmd;
  esf_pkg::sts_t sts;
  logic [esf_pkg::SIZE_W-1:0] left_w, top_w;

  assign cfg_ready = 1'b1;

  esf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .func      (in_func),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  esf_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .coord_x     (in_coord_x),
    .coord_y     (in_coord_y),
    .pixel_value (in_pixel_value),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .left_edge   (left_w),
    .top_edge    (top_w),
    .right_edge  (out_right_edge),
    .bottom_edge (out_bottom_edge),
    .bad_query   (out_bad_query)
  );

  assign out_left_edge = $signed(left_w);
  assign out_top_edge  = $signed(top_w);

endmodule
